[rtl/qrs_pkg.sv]
// Shared types and constants of the quadratic root solver.
`default_nettype none
package qrs_pkg;

  localparam int FRAC_BITS_DEF = 16;   // fractional bits of the Q format
  localparam int COEF_W        = 32;   // coefficient and root width
  localparam int DISC_W        = 66;   // exact discriminant width
  localparam int ROOT_W        = 33;   // square root width
  localparam int SQRT_STEPS    = 33;   // one result bit per stage
  localparam int NMAG_W        = 34;   // numerator magnitude width
  localparam int DEN_W         = 33;   // 2|a| width
  localparam int QUOT_BITS     = 32;   // quotient bits developed by the divider

  typedef enum logic [1:0] {
    ST_REAL     = 2'd0,
    ST_NEG_DISC = 2'd1,
    ST_A_ZERO   = 2'd2,
    ST_SAT      = 2'd3
  } status_t;

  // Side information that travels alongside the square root.
  typedef struct packed {
    logic signed [COEF_W-1:0] b;
    logic [COEF_W-1:0]        a_mag;
    logic                     a_neg;
    status_t                  code;
  } side_t;

endpackage
`default_nettype wire

[rtl/qrs_disc.sv]
// Magnitudes, products and exact discriminant in three register stages.
`default_nettype none
module qrs_disc (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           en,
  input  wire                           vld_in,
  input  wire signed [31:0]             coef_a,
  input  wire signed [31:0]             coef_b,
  input  wire signed [31:0]             coef_c,
  output logic                          vld_out,
  output logic [qrs_pkg::DISC_W-1:0]    d_out,
  output qrs_pkg::side_t                side_out
);
  import qrs_pkg::*;

  logic              vld_a, vld_b;
  logic [COEF_W-1:0] a_mag, b_mag, c_mag, a_mag_b;
  logic              a_neg, c_neg, a_neg_b, pos4ac;
  logic signed [COEF_W-1:0] b_a, b_b;
  logic [63:0]       bb, ac;
  logic [66:0]       d_full;
  logic              d_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a   <= 1'b0;
      vld_b   <= 1'b0;
      vld_out <= 1'b0;
    end else if (en) begin
      vld_a   <= vld_in;
      vld_b   <= vld_a;
      vld_out <= vld_b;
    end
  end

  // Stage one: magnitudes and signs.
  always_ff @(posedge clk) begin
    if (en) begin
      a_neg <= coef_a[31];
      c_neg <= coef_c[31];
      a_mag <= coef_a[31] ? 32'(-coef_a) : 32'(coef_a);
      b_mag <= coef_b[31] ? 32'(-coef_b) : 32'(coef_b);
      c_mag <= coef_c[31] ? 32'(-coef_c) : 32'(coef_c);
      b_a   <= coef_b;
    end
  end

  // Stage two: the two products.
  always_ff @(posedge clk) begin
    if (en) begin
      bb      <= 64'(b_mag) * 64'(b_mag);
      ac      <= 64'(a_mag) * 64'(c_mag);
      pos4ac  <= (a_neg == c_neg);
      a_mag_b <= a_mag;
      a_neg_b <= a_neg;
      b_b     <= b_a;
    end
  end

  // Stage three: d = b*b - 4ac, kept exact; the top bit shows a negative result.
  always_comb begin
    if (pos4ac) d_full = {3'b000, bb} - {1'b0, ac, 2'b00};
    else        d_full = {3'b000, bb} + {1'b0, ac, 2'b00};
    d_neg = d_full[66];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out          <= d_neg ? '0 : d_full[65:0];
      side_out.b     <= b_b;
      side_out.a_mag <= a_mag_b;
      side_out.a_neg <= a_neg_b;
      if (d_neg)              side_out.code <= ST_NEG_DISC;
      else if (a_mag_b == '0) side_out.code <= ST_A_ZERO;
      else                    side_out.code <= ST_REAL;
    end
  end

endmodule
`default_nettype wire

[rtl/qrs_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module qrs_sqrt (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           en,
  input  wire                           vld_in,
  input  wire [qrs_pkg::DISC_W-1:0]     d_in,
  input  qrs_pkg::side_t                side_in,
  output logic                          vld_out,
  output logic [qrs_pkg::ROOT_W-1:0]    root_out,
  output qrs_pkg::side_t                side_out
);
  import qrs_pkg::*;

  logic              vld_s  [SQRT_STEPS+1];
  logic [35:0]       rem_s  [SQRT_STEPS+1];
  logic [ROOT_W-1:0] root_s [SQRT_STEPS+1];
  logic [DISC_W-1:0] d_s    [SQRT_STEPS+1];
  side_t             side_s [SQRT_STEPS+1];

  assign vld_s[0]  = vld_in;
  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign d_s[0]    = d_in;
  assign side_s[0] = side_in;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    logic [1:0]        pair;
    logic [35:0]       rem_sh;
    logic [ROOT_W-1:0] root_sh;
    logic [33:0]       trial;
    logic              take;

    always_comb begin
      pair    = d_s[k][2*(SQRT_STEPS-1-k)+1 -: 2];
      rem_sh  = {rem_s[k][33:0], pair};
      root_sh = {root_s[k][ROOT_W-2:0], 1'b0};
      trial   = {root_sh, 1'b1};
      take    = rem_sh >= {2'b00, trial};
    end

    always_ff @(posedge clk) begin
      if (rst) vld_s[k+1] <= 1'b0;
      else if (en) vld_s[k+1] <= vld_s[k];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k+1]  <= take ? rem_sh - {2'b00, trial} : rem_sh;
        root_s[k+1] <= {root_sh[ROOT_W-1:1], take};
        d_s[k+1]    <= d_s[k];
        side_s[k+1] <= side_s[k];
      end
    end
  end

  assign vld_out  = vld_s[SQRT_STEPS];
  assign root_out = root_s[SQRT_STEPS];
  assign side_out = side_s[SQRT_STEPS];

endmodule
`default_nettype wire

[rtl/qrs_div.sv]
// Two-lane pipelined divider with sign, saturation and status selection.
`default_nettype none
module qrs_div #(
  parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           en,
  input  wire                           vld_in,
  input  wire [qrs_pkg::ROOT_W-1:0]     root_in,
  input  qrs_pkg::side_t                side_in,
  output logic                          vld_out,
  output logic signed [31:0]            root_plus,
  output logic signed [31:0]            root_minus,
  output logic [1:0]                    status
);
  import qrs_pkg::*;

  localparam int NUM_W = NMAG_W + FRAC_BITS;
  localparam int NS    = QUOT_BITS + 1;   // prep stage then one stage per quotient bit

  logic             vld_s  [NS];
  status_t          code_s [NS];
  logic [DEN_W-1:0] den_s  [NS];

  logic [34:0] nb, num [2];

  always_comb begin
    nb     = 35'd0 - {{3{side_in.b[31]}}, side_in.b};
    num[0] = nb + {2'b00, root_in};
    num[1] = nb - {2'b00, root_in};
  end

  // Prep stage: shared control and denominator.
  always_ff @(posedge clk) begin
    if (rst) vld_s[0] <= 1'b0;
    else if (en) vld_s[0] <= vld_in;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      code_s[0] <= side_in.code;
      den_s[0]  <= {side_in.a_mag, 1'b0};
    end
  end

  for (genvar k = 0; k < QUOT_BITS; k++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (rst) vld_s[k+1] <= 1'b0;
      else if (en) vld_s[k+1] <= vld_s[k];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        code_s[k+1] <= code_s[k];
        den_s[k+1]  <= den_s[k];
      end
    end
  end

  logic [QUOT_BITS-1:0] q_fin   [2];
  logic                 neg_fin [2];
  logic                 big_fin [2];

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [NUM_W-1:0]     n_s   [NS];
    logic [DEN_W-1:0]     rem_s [NS];
    logic [QUOT_BITS-1:0] q_s   [NS];
    logic                 neg_s [NS];
    logic                 big_s [NS];
    logic                 nneg;
    logic [NMAG_W-1:0]    nmag;
    logic [NUM_W-1:0]     nsh;

    always_comb begin
      nneg = num[l][34];
      nmag = nneg ? 34'(35'd0 - num[l]) : num[l][NMAG_W-1:0];
      nsh  = {nmag, {FRAC_BITS{1'b0}}};
    end

    // The quotient fits in 32 bits exactly when the bits above them stay below the divisor.
    always_ff @(posedge clk) begin
      if (en) begin
        n_s[0]   <= nsh;
        rem_s[0] <= DEN_W'(nsh >> QUOT_BITS);
        big_s[0] <= 65'(nsh >> QUOT_BITS) >= 65'({side_in.a_mag, 1'b0});
        neg_s[0] <= nneg ^ side_in.a_neg;
        q_s[0]   <= '0;
      end
    end

    for (genvar k = 0; k < QUOT_BITS; k++) begin : g_bit
      logic [DEN_W:0] rem_sh;
      logic           take;

      always_comb begin
        rem_sh = {rem_s[k], n_s[k][QUOT_BITS-1-k]};
        take   = rem_sh >= {1'b0, den_s[k]};
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_s[k+1] <= take ? DEN_W'(rem_sh - {1'b0, den_s[k]}) : rem_sh[DEN_W-1:0];
          q_s[k+1]   <= {q_s[k][QUOT_BITS-2:0], take};
          n_s[k+1]   <= n_s[k];
          neg_s[k+1] <= neg_s[k];
          big_s[k+1] <= big_s[k];
        end
      end
    end

    assign q_fin[l]   = q_s[QUOT_BITS];
    assign neg_fin[l] = neg_s[QUOT_BITS];
    assign big_fin[l] = big_s[QUOT_BITS];
  end

  // Final stage: sign, saturation and status.
  logic [31:0] res [2];
  logic        sat [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (neg_fin[l]) begin
        sat[l] = big_fin[l] || (q_fin[l] > 32'h8000_0000);
        res[l] = sat[l] ? 32'h8000_0000 : 32'd0 - q_fin[l];
      end else begin
        sat[l] = big_fin[l] || q_fin[l][31];
        res[l] = sat[l] ? 32'h7FFF_FFFF : q_fin[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld_out <= 1'b0;
    else if (en) vld_out <= vld_s[QUOT_BITS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (code_s[QUOT_BITS] != ST_REAL) begin
        root_plus  <= '0;
        root_minus <= '0;
        status     <= code_s[QUOT_BITS];
      end else begin
        root_plus  <= res[0];
        root_minus <= res[1];
        status     <= (sat[0] || sat[1]) ? ST_SAT : ST_REAL;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/quadratic_root_solver.sv]
// Top level of the pipelined quadratic root solver.
`default_nettype none
// The block takes one beat of coefficients a, b and c (signed Q16.16 by default) in every
// clock cycle and returns, in the same order, one beat with both real roots of
// a*x^2 + b*x + c = 0 and a status code: 0 for real roots, 1 for a negative discriminant,
// 2 for a zero a and 3 when a root saturated. Three stages form the
// exact discriminant, 33 stages develop the truncated square root one bit each, and the
// divider spends one stage on setup, 32 stages on quotient bits and one on the output
// register. A new beat is accepted in every cycle in which no finished beat is stalled at
// the output; while one is, the whole pipeline holds.
module quadratic_root_solver #(
  parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire signed [31:0] coef_a,
  input  wire signed [31:0] coef_b,
  input  wire signed [31:0] coef_c,
  output logic              out_valid,
  input  wire               out_stall,
  output logic signed [31:0] root_plus,
  output logic signed [31:0] root_minus,
  output logic [1:0]        status
);
  import qrs_pkg::*;

  // Every stage moves forward together unless the output register holds an untaken beat.
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  logic              d_vld, s_vld;
  logic [DISC_W-1:0] d;
  logic [ROOT_W-1:0] s;
  side_t             d_side, s_side;

  // Magnitudes, both products and the exact discriminant.
  qrs_disc u_disc (
    .clk(clk), .rst(rst), .en(en), .vld_in(in_valid),
    .coef_a(coef_a), .coef_b(coef_b), .coef_c(coef_c),
    .vld_out(d_vld), .d_out(d), .side_out(d_side)
  );

  // Truncated square root of the discriminant, with the coefficient data alongside.
  qrs_sqrt u_sqrt (
    .clk(clk), .rst(rst), .en(en), .vld_in(d_vld), .d_in(d), .side_in(d_side),
    .vld_out(s_vld), .root_out(s), .side_out(s_side)
  );

  // Both quotients, saturation and the final output register.
  qrs_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .en(en), .vld_in(s_vld), .root_in(s), .side_in(s_side),
    .vld_out(out_valid), .root_plus(root_plus), .root_minus(root_minus), .status(status)
  );

endmodule
`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the pipelined quadratic root solver.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import qrs_pkg::*;

  localparam int FB = 16;
  localparam int N_RANDOM = 1750;
  localparam int LATENCY = 70;
  localparam longint CYCLE_LIMIT = 400000;

  // One expected result as it should leave the block.
  typedef struct {
    logic signed [31:0] rp;
    logic signed [31:0] rm;
    status_t            st;
  } roots_t;

  // A row of the directed table; when known is set the expected roots are typed in.
  typedef struct {
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
    bit                 known;
    roots_t             res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  logic signed [31:0] coef_a = '0, coef_b = '0, coef_c = '0;
  wire in_stall, out_valid;
  wire signed [31:0] root_plus, root_minus;
  wire [1:0] status;

  roots_t pending_roots[$];
  int errors = 0;
  int n_checked = 0;
  longint cycles = 0;
  bit quiet = 1'b0;       // set near the end: no idling on either side
  bit draining = 1'b0;

  always #10 clk = ~clk;

  quadratic_root_solver u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .coef_a(coef_a), .coef_b(coef_b), .coef_c(coef_c),
    .out_valid(out_valid), .out_stall(out_stall),
    .root_plus(root_plus), .root_minus(root_minus), .status(status)
  );

  // Integer square root of an unsigned 66-bit value, truncated, two bits per step.
  function automatic logic [32:0] sqrt_trunc(input logic [65:0] d);
    logic [67:0] rem;
    logic [33:0] root;
    logic [67:0] trial;
    rem = '0;
    root = '0;
    for (int i = 32; i >= 0; i--) begin
      rem = (rem << 2) | 68'(d[2*i +: 2]);
      root = root << 1;
      trial = (68'(root) << 1) | 68'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = root | 34'd1;
      end
    end
    return root[32:0];
  endfunction

  // Fixed-point quotient num/den with truncation toward zero, saturated to 32 bits.
  function automatic logic signed [31:0] fixed_div(input logic signed [34:0] num,
                                                   input logic [32:0] den,
                                                   input bit den_neg,
                                                   inout bit sat);
    logic [34:0] nmag;
    logic [63:0] q;
    bit neg;
    nmag = num[34] ? 35'(-num) : 35'(num);
    q = (64'(nmag) << FB) / 64'(den);
    neg = num[34] ^ den_neg;
    if (neg) begin
      if (q > 64'h8000_0000) begin
        sat = 1'b1;
        return 32'sh8000_0000;
      end
      return 32'(-q);
    end
    if (q > 64'h7FFF_FFFF) begin
      sat = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    return 32'(q);
  endfunction

  // Predicts the roots of a*x^2 + b*x + c from the exact discriminant.
  function automatic roots_t solve_roots(input logic signed [31:0] a,
                                         input logic signed [31:0] b,
                                         input logic signed [31:0] c);
    roots_t r;
    logic signed [67:0] disc;
    logic [32:0] s;
    logic [32:0] a_mag;
    bit sat;
    r.rp = '0;
    r.rm = '0;
    sat = 1'b0;
    disc = 68'(b) * 68'(b) - 68'sd4 * 68'(a) * 68'(c);
    if (disc < 0) begin
      r.st = ST_NEG_DISC;
      return r;
    end
    if (a == 0) begin
      r.st = ST_A_ZERO;
      return r;
    end
    s = sqrt_trunc(disc[65:0]);
    a_mag = a[31] ? 33'(-34'(a)) : 33'(a);
    r.rp = fixed_div(-35'(b) + 35'(s), a_mag << 1, a[31], sat);
    r.rm = fixed_div(-35'(b) - 35'(s), a_mag << 1, a[31], sat);
    r.st = sat ? ST_SAT : ST_REAL;
    return r;
  endfunction

  // Drives one beat and holds it until accepted; idles before it at random.
  task automatic send_beat(input logic signed [31:0] a, input logic signed [31:0] b,
                           input logic signed [31:0] c, input roots_t res);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    coef_a <= a;
    coef_b <= b;
    coef_c <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_roots.push_back(res);
  endtask

  // Random coefficient with a spread of magnitudes so that every status comes up.
  function automatic logic signed [31:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
      2: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
      3: return $urandom_range(0, 3) == 0 ? 32'sh0 : 32'sh8000_0000 + $urandom_range(0, 3);
      4: return $signed($urandom_range(0, 1023)) - 32'sd512;
      default: return $signed($urandom) >>> $urandom_range(0, 31);
    endcase
  endfunction

  // Receiver: random stall bursts, checks each accepted beat against the oldest expectation.
  initial begin
    roots_t want;
    forever begin
      @(posedge clk);
      cycles++;
      if (!rst && out_valid && !out_stall) begin
        if (pending_roots.size() == 0) begin
          $display("%0t: unexpected beat rp=%h rm=%h st=%0d", $time,
                   root_plus, root_minus, status);
          errors++;
        end else begin
          want = pending_roots.pop_front();
          n_checked++;
          if (root_plus !== want.rp) begin
            $display("%0t: root_plus expected %h actual %h", $time, want.rp, root_plus);
            errors++;
          end
          if (root_minus !== want.rm) begin
            $display("%0t: root_minus expected %h actual %h", $time, want.rm, root_minus);
            errors++;
          end
          if (status !== 2'(want.st)) begin
            $display("%0t: status expected %0d actual %0d", $time, want.st, status);
            errors++;
          end
        end
      end
      if (!quiet && !out_stall && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) begin
          @(posedge clk);
          cycles++;
        end
      end
      out_stall <= 1'b0;
      if (cycles > CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles", cycles);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Stimulus: directed table first, then random equations, then the drain.
  initial begin
    row_t rows[$];
    roots_t z;
    roots_t e;
    logic signed [31:0] a, b, c;
    int wait_cnt;
    z.rp = '0;
    z.rm = '0;
    z.st = ST_A_ZERO;
    // x^2 - 3x + 2: roots 2 and 1.
    e.rp = 32'sh0002_0000; e.rm = 32'sh0001_0000; e.st = ST_REAL;
    rows.push_back('{32'sh0001_0000, -32'sh0003_0000, 32'sh0002_0000, 1'b1, e});
    // x^2 + 1: negative discriminant.
    e.rp = '0; e.rm = '0; e.st = ST_NEG_DISC;
    rows.push_back('{32'sh0001_0000, 32'sh0, 32'sh0001_0000, 1'b1, e});
    // a is zero, with extreme or zero b and c.
    rows.push_back('{32'sh0, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1, z});
    rows.push_back('{32'sh0, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1, z});
    rows.push_back('{32'sh0, 32'sh0, 32'sh0, 1'b1, z});
    // All zero except a: both roots are zero, negative zero folds to zero.
    e.rp = '0; e.rm = '0; e.st = ST_REAL;
    rows.push_back('{32'sh8000_0000, 32'sh0, 32'sh0, 1'b1, e});
    rows.push_back('{32'sh0000_0001, 32'sh0, 32'sh0, 1'b1, e});
    // Extremes, saturation cases and ordinary equations, left to the predictor.
    rows.push_back('{32'sh0000_0001, 32'sh7FFF_FFFF, 32'sh0, 1'b0, e});
    rows.push_back('{32'sh0000_0001, 32'sh8000_0000, 32'sh8000_0000, 1'b0, e});
    rows.push_back('{32'shFFFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, e});
    rows.push_back('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0, e});
    rows.push_back('{32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, e});
    rows.push_back('{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, e});
    rows.push_back('{32'sh7FFF_FFFF, 32'sh0, 32'sh7FFF_FFFF, 1'b0, e});
    rows.push_back('{32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 1'b0, e});
    rows.push_back('{32'sh0001_0000, 32'sh0002_0000, 32'sh0001_0000, 1'b0, e});
    rows.push_back('{-32'sh0002_0000, 32'sh0000_8000, 32'sh0005_0000, 1'b0, e});
    rows.push_back('{32'sh0000_0002, 32'sh0000_0004, 32'sh0000_0002, 1'b0, e});

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i])
      send_beat(rows[i].a, rows[i].b, rows[i].c,
                rows[i].known ? rows[i].res : solve_roots(rows[i].a, rows[i].b, rows[i].c));

    for (int n = 0; n < N_RANDOM; n++) begin
      // Once, mid-run, hold off until the pipeline has delivered everything.
      if (n == N_RANDOM / 2) begin
        in_valid <= 1'b0;
        while (pending_roots.size() != 0) @(posedge clk);
      end
      if (n == N_RANDOM - 200) quiet = 1'b1;
      a = rand_coef();
      b = rand_coef();
      c = rand_coef();
      send_beat(a, b, c, solve_roots(a, b, c));
    end
    in_valid <= 1'b0;

    // Drain: wait for every expected beat, then wait on with the input idle.
    while (pending_roots.size() != 0) @(posedge clk);
    wait_cnt = 0;
    while (wait_cnt < 2 * LATENCY) begin
      @(posedge clk);
      wait_cnt++;
    end

    $display("Ran %0d directed and %0d random equations; %0d results checked.",
             rows.size(), N_RANDOM, n_checked);
    $display("Statuses covered: real roots, negative discriminant, zero a, saturation.");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire

[sim.f]
rtl/qrs_pkg.sv
rtl/qrs_disc.sv
rtl/qrs_sqrt.sv
rtl/qrs_div.sv
rtl/quadratic_root_solver.sv
tb/testbench.sv
